### design/sleep_wakeup_timer_table_top_defines.svh
// ----------------------------------------------------------------------------
// sleep wakeup timer table: assertion macros
// Shared property shorthands for the checker. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SLEEP_WAKEUP_TIMER_TABLE_TOP_DEFINES_SVH
`define SLEEP_WAKEUP_TIMER_TABLE_TOP_DEFINES_SVH

// antecedent and consequent in the same cycle
`define SWTT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define SWTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/swtt_pkg.sv
// ----------------------------------------------------------------------------
// swtt_pkg
// Shared constants, codes and types of the sleep wakeup timer table.
// ----------------------------------------------------------------------------
package swtt_pkg;

    localparam int SLOTS     = 16;
    localparam int TICK_BITS = 48;
    localparam int ID_BITS   = 8;

    // slot index and slot count widths
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);

    // one table entry holds {wake tick, thread id}
    localparam int ENT_W = ID_BITS + TICK_BITS;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_BITS = ID_BITS + TICK_BITS + 1;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = 1 + ID_BITS + 2 + TICK_BITS;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

    // opcodes
    localparam logic OP_SLEEP = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_IDLE = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [TICK_BITS-1:0] TICK_NONE = {TICK_BITS{1'b1}};

    typedef struct packed {
        logic                 woken_valid;
        logic [ID_BITS-1:0]   woken_id;
        logic [1:0]           status;
        logic [TICK_BITS-1:0] next_wake;
        logic                 last;
    } res_t;

endpackage

### design/sleep_wakeup_timer_table_top.sv
// ----------------------------------------------------------------------------
// sleep_wakeup_timer_table_top
// Table of sleeping threads with wake ticks, kept in arrival order in a RAM.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                 | tuser  | tlast
//  s_axis  | in  | thread_id, tick_value, requester_idle | opcode | -
//  m_axis  | out | woken_valid, woken_id, status, next   | -      | last
//
//  a sleep transaction is taken in and its result registered, then moved to the
//  output register; a tick scan reads the stored entries one entry per cycle
//  through the entry RAM read port, then reads each released thread back from
//  the woken buffer into the output register (one result when none is released).
//  reset clears the state machine, the entry count and the earliest wake tick;
//  RAM contents need no clearing since only entries below the count are read.
//  input is taken only when the scan engine is idle; output stalls hold it.
// ----------------------------------------------------------------------------
module sleep_wakeup_timer_table_top
    import swtt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // thread_id, tick_value, requester_idle
    input  logic                 s_tuser,  // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // woken_valid, woken_id, status, next_wake
    output logic                 m_tlast
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PUSH    = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_EMIT_RD = 3'd3;
    localparam logic [2:0] ST_EMIT_WR = 3'd4;

    // input fields
    logic [ID_BITS-1:0]   in_id;
    logic [TICK_BITS-1:0] in_tick;
    logic                 in_idle;

    assign in_id   = s_tdata[ID_BITS-1:0];
    assign in_tick = s_tdata[ID_BITS+TICK_BITS-1:ID_BITS];
    assign in_idle = s_tdata[ID_BITS+TICK_BITS];

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TICK_BITS-1:0] earliest_reg, earliest_next;
    logic [TICK_BITS-1:0] scan_tick_reg, scan_tick_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0]     keep_reg, keep_next;
    logic [CNT_W-1:0]     nw_reg, nw_next;
    logic [TICK_BITS-1:0] min_reg, min_next;
    logic [CNT_W-1:0]     emit_reg, emit_next;
    res_t                 pend_reg, pend_next;
    res_t                 out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    // entry RAM ports
    logic               ent_we, ent_re;
    logic [SLOT_AW-1:0] ent_waddr, ent_raddr;
    logic [ENT_W-1:0]   ent_wdata, ent_rdata;

    // woken buffer ports
    logic               wk_we, wk_re;
    logic [SLOT_AW-1:0] wk_waddr, wk_raddr;
    logic [ID_BITS-1:0] wk_wdata, wk_rdata;

    logic                 accept;
    logic                 out_free;
    logic [ID_BITS-1:0]   rd_id;
    logic [TICK_BITS-1:0] rd_wake;
    logic [CNT_W-1:0]     emit_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign rd_id    = ent_rdata[ID_BITS-1:0];
    assign rd_wake  = ent_rdata[ENT_W-1:ID_BITS];
    assign emit_inc = emit_reg + CNT_W'(1);

    swtt_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    swtt_ram #(.WIDTH(ID_BITS), .DEPTH(SLOTS)) u_woken_ram (
        .clk   (clk),
        .we    (wk_we),
        .waddr (wk_waddr),
        .wdata (wk_wdata),
        .re    (wk_re),
        .raddr (wk_raddr),
        .rdata (wk_rdata)
    );

    // control and datapath
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        earliest_next  = earliest_reg;
        scan_tick_next = scan_tick_reg;
        issue_next     = issue_reg;
        rd_pend_next   = rd_pend_reg;
        keep_next      = keep_reg;
        nw_next        = nw_reg;
        min_next       = min_reg;
        emit_next      = emit_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;

        ent_we    = 1'b0;
        ent_waddr = count_reg[SLOT_AW-1:0];
        ent_wdata = {in_tick, in_id};
        ent_re    = 1'b0;
        ent_raddr = issue_reg[SLOT_AW-1:0];
        wk_we     = 1'b0;
        wk_waddr  = nw_reg[SLOT_AW-1:0];
        wk_wdata  = rd_id;
        wk_re     = 1'b0;
        wk_raddr  = emit_reg[SLOT_AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == OP_SLEEP)
                    begin
                        pend_next.woken_valid = 1'b0;
                        pend_next.woken_id    = '0;
                        pend_next.last        = 1'b1;
                        pend_next.next_wake   = earliest_reg;
                        if (in_idle)
                        begin
                            pend_next.status = STATUS_IDLE;
                        end
                        else if (count_reg == CNT_W'(SLOTS))
                        begin
                            pend_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            // append at the end of the used prefix
                            pend_next.status = STATUS_OK;
                            ent_we           = 1'b1;
                            count_next       = count_reg + CNT_W'(1);
                            if (in_tick < earliest_reg)
                            begin
                                earliest_next       = in_tick;
                                pend_next.next_wake = in_tick;
                            end
                        end
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        scan_tick_next = in_tick;
                        issue_next     = '0;
                        rd_pend_next   = 1'b0;
                        keep_next      = '0;
                        nw_next        = '0;
                        min_next       = TICK_NONE;
                        emit_next      = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_PUSH:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // process the entry read last cycle: release or compact
                if (rd_pend_reg)
                begin
                    if (rd_wake <= scan_tick_reg)
                    begin
                        wk_we   = 1'b1;
                        nw_next = nw_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ent_we    = 1'b1;
                        ent_waddr = keep_reg[SLOT_AW-1:0];
                        ent_wdata = ent_rdata;
                        keep_next = keep_reg + CNT_W'(1);
                        if (rd_wake < min_reg)
                        begin
                            min_next = rd_wake;
                        end
                    end
                end
                // issue the next read; writes stay at or below the entry just read
                if (issue_reg != count_reg)
                begin
                    ent_re       = 1'b1;
                    issue_next   = issue_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
                // scan complete
                if (!rd_pend_reg && (issue_reg == count_reg))
                begin
                    count_next    = keep_reg;
                    earliest_next = min_reg;
                    if (nw_reg == '0)
                    begin
                        pend_next.woken_valid = 1'b0;
                        pend_next.woken_id    = '0;
                        pend_next.status      = STATUS_OK;
                        pend_next.next_wake   = min_reg;
                        pend_next.last        = 1'b1;
                        state_next            = ST_PUSH;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            ST_EMIT_RD:
            begin
                wk_re      = 1'b1;
                state_next = ST_EMIT_WR;
            end

            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_next.woken_valid = 1'b1;
                    out_next.woken_id    = wk_rdata;
                    out_next.status      = STATUS_OK;
                    out_next.next_wake   = earliest_reg;
                    out_next.last        = (emit_inc == nw_reg);
                    out_valid_next       = 1'b1;
                    emit_next            = emit_inc;
                    state_next           = (emit_inc == nw_reg) ? ST_IDLE : ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            earliest_reg  <= TICK_NONE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            earliest_reg  <= earliest_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        scan_tick_reg <= scan_tick_next;
        issue_reg     <= issue_next;
        keep_reg      <= keep_next;
        nw_reg        <= nw_next;
        min_reg       <= min_next;
        emit_reg      <= emit_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = M_TDATA_W'({out_reg.next_wake, out_reg.status,
                                  out_reg.woken_id, out_reg.woken_valid});

endmodule

### design/swtt_ram.sv
// ----------------------------------------------------------------------------
// swtt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module swtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/swtt_checker.sv
// ----------------------------------------------------------------------------
// swtt_checker
// Port-level assertions for the sleep wakeup timer table, bound to the top.
// ----------------------------------------------------------------------------
`include "sleep_wakeup_timer_table_top_defines.svh"

module swtt_checker
    import swtt_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    logic       o_valid;
    logic [1:0] o_status;
    logic [ID_BITS-1:0] o_id;
    logic [M_TDATA_W:0] o_beat;
    logic       out_stall;
    logic       o_refused;
    logic       o_empty;
    logic       o_mid_run;

    assign o_valid  = m_tdata[0];
    assign o_id     = m_tdata[ID_BITS:1];
    assign o_status = m_tdata[ID_BITS+2:ID_BITS+1];

    // output transaction as seen on the ports, and the cases checked below
    assign o_beat    = {m_tlast, m_tdata};
    assign out_stall = m_tvalid && !m_tready;
    assign o_refused = m_tvalid && (o_status != STATUS_OK);
    assign o_empty   = m_tvalid && !o_valid;
    assign o_mid_run = m_tvalid && o_valid && !m_tlast;

    // stalled output transaction holds
    `SWTT_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(o_beat), "stalled output changed")

    // refused sleeps release nothing and end their run
    `SWTT_ASSERT_SAME(a_refused_single, o_refused, !o_valid && m_tlast, "bad refused result")

    // results that release nothing carry id zero and end their run
    `SWTT_ASSERT_SAME(a_nowake_clean, o_empty, (o_id == '0) && m_tlast, "bad empty result")

    // no input is taken while a released run is still being delivered
    `SWTT_ASSERT_SAME(a_run_blocks_input, o_mid_run, !s_tready, "input ready during wake run")

endmodule

bind sleep_wakeup_timer_table_top swtt_checker u_swtt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### test/sleep_wakeup_timer_table_top_test.sv
// ----------------------------------------------------------------------------
// sleep_wakeup_timer_table_top_test
// Checks the sleep table against a behavioral model of its entry list.
// Sleep and tick transactions go in on the input stream, and every
// result is compared with the oldest outstanding prediction. A short
// directed run covers the empty, full, idle-thread, duplicate-id and
// extreme-tick cases, and a long random run follows. Both stream sides
// idle at random, and the output side holds off for one long stretch.
// ----------------------------------------------------------------------------
module sleep_wakeup_timer_table_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swtt_pkg::*;

    localparam int IDLE_MAX       = 17;
    localparam int HOLD_AT        = 100;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 385;
    localparam int DIRECTED_COUNT = 25;

    typedef struct packed {
        logic                 op;
        logic [ID_BITS-1:0]   thread_id;
        logic [TICK_BITS-1:0] tick;
        logic                 idle;
    } request_t;

    typedef struct packed {
        request_t req;
        logic     has_fixed;
        res_t     fixed;
    } stim_row_t;

    typedef struct packed {
        logic [ID_BITS-1:0]   thread_id;
        logic [TICK_BITS-1:0] wake;
    } sleeper_t;

    // directed rows; a fixed result is given only where it is obvious
    localparam stim_row_t DIRECTED [DIRECTED_COUNT] = '{
        // scan of the empty table
        '{'{OP_TICK,  8'h5a, 48'h0, 1'b0}, 1'b1, '{1'b0, 8'h00, STATUS_OK, TICK_NONE, 1'b1}},
        // idle thread asks to sleep
        '{'{OP_SLEEP, 8'haa, 48'h123, 1'b1}, 1'b1,
            '{1'b0, 8'h00, STATUS_IDLE, TICK_NONE, 1'b1}},
        '{'{OP_SLEEP, 8'hff, 48'h0, 1'b0}, 1'b1, '{1'b0, 8'h00, STATUS_OK, 48'h0, 1'b1}},
        '{'{OP_SLEEP, 8'h00, TICK_NONE, 1'b0}, 1'b0, '0},
        // same id again
        '{'{OP_SLEEP, 8'hff, 48'd5, 1'b0}, 1'b0, '0},
        '{'{OP_SLEEP, 8'h55, 48'haaaa_aaaa_aaaa, 1'b0}, 1'b0, '0},
        '{'{OP_SLEEP, 8'haa, 48'h5555_5555_5555, 1'b0}, 1'b0, '0},
        '{'{OP_SLEEP, 8'h01, 48'd300, 1'b0}, 1'b0, '0},
        '{'{OP_SLEEP, 8'h02, 48'd40, 1'b0}, 1'b0, '0},
        '{'{OP_SLEEP, 8'h03, 48'd7, 1'b0}, 1'b0, '0},
        '{'{OP_SLEEP, 8'h04, 48'd900, 1'b0}, 1'b0, '0},
        '{'{OP_SLEEP, 8'h05, 48'd40, 1'b0}, 1'b0, '0},
        '{'{OP_SLEEP, 8'h06, 48'h8000_0000_0000, 1'b0}, 1'b0, '0},
        '{'{OP_SLEEP, 8'h07, 48'd6, 1'b0}, 1'b0, '0},
        '{'{OP_SLEEP, 8'h08, 48'd1, 1'b0}, 1'b0, '0},
        '{'{OP_SLEEP, 8'h09, 48'd5000, 1'b0}, 1'b0, '0},
        '{'{OP_SLEEP, 8'h0a, 48'd20, 1'b0}, 1'b0, '0},
        '{'{OP_SLEEP, 8'h0b, 48'd64, 1'b0}, 1'b0, '0},
        // table is full now
        '{'{OP_SLEEP, 8'h0c, 48'd3, 1'b0}, 1'b1, '{1'b0, 8'h00, STATUS_FULL, 48'h0, 1'b1}},
        '{'{OP_SLEEP, 8'h0d, 48'd2, 1'b1}, 1'b1, '{1'b0, 8'h00, STATUS_IDLE, 48'h0, 1'b1}},
        // scans: a few, equal ticks, all but the all-ones entry, everything
        '{'{OP_TICK,  8'hff, 48'd5, 1'b0}, 1'b0, '0},
        '{'{OP_TICK,  8'h00, 48'd40, 1'b1}, 1'b0, '0},
        '{'{OP_TICK,  8'h33, TICK_NONE - 48'd1, 1'b0}, 1'b0, '0},
        '{'{OP_TICK,  8'hcc, TICK_NONE, 1'b0}, 1'b0, '0},
        '{'{OP_TICK,  8'h00, 48'h0, 1'b0}, 1'b1, '{1'b0, 8'h00, STATUS_OK, TICK_NONE, 1'b1}}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // model of the sleeping threads, in arrival order
    sleeper_t             sleepers[$];
    logic [TICK_BITS-1:0] earliest_pending;
    res_t                 pending_results[$];
    int unsigned          mismatches;
    int unsigned          results_seen;

    sleep_wakeup_timer_table_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic res_t make_result(logic valid, logic [ID_BITS-1:0] id,
                                         logic [1:0] status,
                                         logic [TICK_BITS-1:0] next_wake,
                                         logic last);
        res_t r;
        r.woken_valid = valid;
        r.woken_id    = id;
        r.status      = status;
        r.next_wake   = next_wake;
        r.last        = last;
        return r;
    endfunction

    // update the sleeper list and queue the results one transaction causes
    function automatic void predict_wakeups(request_t req);
        sleeper_t             survivors[$];
        logic [ID_BITS-1:0]   released[$];
        logic [TICK_BITS-1:0] new_min;
        sleeper_t             entry;
        if (req.op == OP_SLEEP)
        begin
            if (req.idle)
                pending_results.push_back(
                    make_result(1'b0, '0, STATUS_IDLE, earliest_pending, 1'b1));
            else if (sleepers.size() >= SLOTS)
                pending_results.push_back(
                    make_result(1'b0, '0, STATUS_FULL, earliest_pending, 1'b1));
            else
            begin
                entry.thread_id = req.thread_id;
                entry.wake      = req.tick;
                sleepers.push_back(entry);
                if (req.tick < earliest_pending)
                    earliest_pending = req.tick;
                pending_results.push_back(
                    make_result(1'b0, '0, STATUS_OK, earliest_pending, 1'b1));
            end
        end
        else
        begin
            new_min = TICK_NONE;
            foreach (sleepers[i])
            begin
                if (sleepers[i].wake <= req.tick)
                    released.push_back(sleepers[i].thread_id);
                else
                begin
                    survivors.push_back(sleepers[i]);
                    if (sleepers[i].wake < new_min)
                        new_min = sleepers[i].wake;
                end
            end
            sleepers = survivors;
            earliest_pending = new_min;
            if (released.size() == 0)
                pending_results.push_back(
                    make_result(1'b0, '0, STATUS_OK, earliest_pending, 1'b1));
            else
                foreach (released[i])
                    pending_results.push_back(
                        make_result(1'b1, released[i], STATUS_OK, earliest_pending,
                                    i == released.size() - 1));
        end
    endfunction

    // offer one transaction after a random gap and predict on acceptance
    task automatic send_request(request_t req, logic has_fixed, res_t fixed, bit burst);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.op;
        s_tdata  <= S_TDATA_W'({req.idle, req.tick, req.thread_id});
        do
            @(posedge clk);
        while (!s_tready);
        predict_wakeups(req);
        if (has_fixed)
        begin
            void'(pending_results.pop_back());
            pending_results.push_back(fixed);
        end
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // stimulus
    initial
    begin
        request_t             req;
        logic [TICK_BITS-1:0] now_tick;
        int unsigned          pick;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        sleepers.delete();
        earliest_pending = TICK_NONE;
        mismatches = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_request(DIRECTED[i].req, DIRECTED[i].has_fixed, DIRECTED[i].fixed, 1'b0);

        // random run: mostly sleeps just ahead of a moving clock, scans in between
        now_tick = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                now_tick = TICK_NONE - 48'd30000;
            pick = $urandom_range(0, 99);
            req.op        = OP_SLEEP;
            req.thread_id = ID_BITS'($urandom);
            req.idle      = 1'b0;
            if (pick < 6)
            begin
                req.idle = 1'b1;
                req.tick = TICK_BITS'({$urandom, $urandom});
            end
            else if (pick < 9)
                req.tick = TICK_BITS'({$urandom, $urandom});
            else if (pick < 68)
                req.tick = now_tick + TICK_BITS'($urandom_range(0, 300));
            else if (pick < 96)
            begin
                now_tick = now_tick + TICK_BITS'($urandom_range(0, 120));
                req.op   = OP_TICK;
                req.tick = now_tick;
            end
            else
            begin
                req.op   = OP_TICK;
                req.tick = pick[0] ? TICK_NONE : TICK_BITS'({$urandom, $urandom});
            end
            send_request(req, 1'b0, '0, (n % 64) < 12);
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS sleep_wakeup_timer_table_top");
        else
            $display("FAIL sleep_wakeup_timer_table_top");
        $finish;
    end

    // result side: random stalls, one long hold-off, compare each transaction
    initial
    begin
        int unsigned stall;
        res_t        got;
        res_t        want;
        m_tready <= 1'b0;
        results_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (results_seen == HOLD_AT)
                stall = HOLD_CYCLES;
            else if ((results_seen % 50) < 10)
                stall = 0;
            else
                stall = $urandom_range(0, IDLE_MAX);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            results_seen++;
            got.woken_valid = m_tdata[0];
            got.woken_id    = m_tdata[ID_BITS:1];
            got.status      = m_tdata[ID_BITS+2:ID_BITS+1];
            got.next_wake   = m_tdata[ID_BITS+2+TICK_BITS:ID_BITS+3];
            got.last        = m_tlast;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result woken_id %0h next_wake %0h",
                       got.woken_id, got.next_wake);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("woken_valid", 64'(want.woken_valid), 64'(got.woken_valid));
                check_field("woken_id", 64'(want.woken_id), 64'(got.woken_id));
                check_field("status", 64'(want.status), 64'(got.status));
                check_field("next_wake", 64'(want.next_wake), 64'(got.next_wake));
                check_field("last", 64'(want.last), 64'(got.last));
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL sleep_wakeup_timer_table_top");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/swtt_pkg.sv
design/swtt_ram.sv
design/sleep_wakeup_timer_table_top.sv
design/swtt_checker.sv
test/sleep_wakeup_timer_table_top_test.sv
